FILE: sv/cfgl_pkg.sv
// Shared types and constants for the segment-map glyph lookup block.
`timescale 1ns / 1ps

package cfgl_pkg;

   localparam logic [1:0] OP_LOAD_SEGMENT = 2'd0;
   localparam logic [1:0] OP_LOAD_WORD    = 2'd1;
   localparam logic [1:0] OP_LOOKUP       = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic [9:0]         entry_index;
      logic [15:0]        last_code;
      logic [15:0]        first_code;
      logic signed [15:0] glyph_delta;
      logic [15:0]        range_offset;
      logic [15:0]        glyph_word;
      logic [15:0]        char_code;
   } req_data_type;

   typedef struct packed {
      logic [15:0] glyph_id;
      logic        segment_found;
   } rsp_data_type;

   typedef struct packed {
      logic [15:0] last_code;
      logic [15:0] first_code;
      logic [15:0] glyph_delta;
      logic [15:0] range_offset;
   } seg_entry_type;

   typedef enum logic [1:0] {
      RES_MISS,
      RES_EMPTY,
      RES_DIRECT,
      RES_WORD
   } res_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CALC,
      ST_GREAD,
      ST_GWAIT,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic        seg_wr;
      logic        word_wr;
      logic        code_load;
      logic        scan_clear;
      logic        rd_en;
      logic        addr_load;
      logic        glyph_rd;
      logic        res_load;
      res_sel_type res_sel;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic used_zero;
      logic issue_more;
      logic chk_valid;
      logic end_ge;
      logic start_le;
      logic roff_zero;
      logic scan_last;
      logic in_range;
   } stat_type;

endpackage

FILE: sv/cfgl_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps

interface cfgl_req_if;
   import cfgl_pkg::*;
   logic         valid;
   logic         ready;
   req_data_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface cfgl_rsp_if;
   import cfgl_pkg::*;
   logic         valid;
   logic         ready;
   rsp_data_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: sv/cfgl_dp.sv
// Datapath: segment and glyph word memories, scan counter, address and result logic.
`timescale 1ns / 1ps

module cfgl_dp #(
   parameter int MAX_SEGMENTS = 64,
   parameter int GLYPH_WORDS  = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfgl_pkg::req_data_type req_data,
   input  cfgl_pkg::cmd_type      cmd,
   input  logic                  csr_wr_en,
   input  logic [6:0]            csr_wr_data,
   output cfgl_pkg::stat_type     stat,
   output cfgl_pkg::rsp_data_type rsp_data
);
   import cfgl_pkg::*;

   localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int UW     = $clog2(MAX_SEGMENTS + 1);
   localparam int GW_AW  = $clog2(GLYPH_WORDS);
   localparam int IW     = 17;
   localparam int AW     = 19;

   seg_entry_type seg_mem [MAX_SEGMENTS];
   logic [15:0]   word_mem [GLYPH_WORDS];

   logic [6:0]        count_ff;
   logic [UW-1:0]     used;
   logic [15:0]       code_ff;
   logic [UW-1:0]     issue_ff;
   logic              chk_valid_ff;
   logic [SEG_AW-1:0] chk_seg_ff;
   seg_entry_type     seg_rd_ff;
   logic [AW-1:0]     addr_ff;
   logic [AW-1:0]     addr_in;
   logic [15:0]       word_rd_ff;
   logic [15:0]       res_glyph_ff;
   logic [15:0]       res_glyph_in;
   logic              res_found_ff;
   logic              res_found_in;
   logic [15:0]       rsp_glyph_ff;
   logic              rsp_found_ff;
   logic [IW-1:0]     idx_ext;
   logic              seg_idx_ok;
   logic              word_idx_ok;
   logic [15:0]       code_diff;

   // saturate the segment count to the table depth
   always_comb begin
      if (11'(count_ff) > 11'(MAX_SEGMENTS)) begin
         used = UW'(MAX_SEGMENTS);
      end else begin
         used = UW'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 7'd1;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   assign idx_ext     = IW'(req_data.entry_index);
   assign seg_idx_ok  = idx_ext < IW'(MAX_SEGMENTS);
   assign word_idx_ok = idx_ext < IW'(GLYPH_WORDS);

   always_ff @(posedge clock) begin
      if (cmd.seg_wr && seg_idx_ok) begin
         seg_mem[req_data.entry_index[SEG_AW-1:0]] <= '{
            last_code:    req_data.last_code,
            first_code:   req_data.first_code,
            glyph_delta:  req_data.glyph_delta,
            range_offset: req_data.range_offset
         };
      end
      if (cmd.rd_en) begin
         seg_rd_ff  <= seg_mem[issue_ff[SEG_AW-1:0]];
         chk_seg_ff <= issue_ff[SEG_AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.word_wr && word_idx_ok) begin
         word_mem[idx_ext[GW_AW-1:0]] <= req_data.glyph_word;
      end
      if (cmd.glyph_rd) begin
         word_rd_ff <= word_mem[addr_ff[GW_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff     <= '0;
         chk_valid_ff <= 1'b0;
      end else if (cmd.scan_clear) begin
         issue_ff     <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         if (cmd.rd_en) begin
            issue_ff <= issue_ff + UW'(1);
         end
         chk_valid_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.code_load) begin
         code_ff <= req_data.char_code;
      end
   end

   // word address past the range-offset array, relative to the glyph word store
   assign code_diff = code_ff - seg_rd_ff.first_code;
   assign addr_in   = AW'(chk_seg_ff) + AW'(seg_rd_ff.range_offset[15:1])
                    + AW'(code_diff) - AW'(used);

   always_ff @(posedge clock) begin
      if (cmd.addr_load) begin
         addr_ff <= addr_in;
      end
   end

   always_comb begin
      res_glyph_in = 16'd0;
      res_found_in = 1'b1;
      unique case (cmd.res_sel)
         RES_MISS: begin
            res_found_in = 1'b0;
         end
         RES_EMPTY: begin
            res_glyph_in = 16'd0;
         end
         RES_DIRECT: begin
            res_glyph_in = code_ff + seg_rd_ff.glyph_delta;
         end
         RES_WORD: begin
            if (word_rd_ff != 16'd0) begin
               res_glyph_in = word_rd_ff + seg_rd_ff.glyph_delta;
            end
         end
         default: begin
            res_found_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_glyph_ff <= res_glyph_in;
         res_found_ff <= res_found_in;
      end
      if (cmd.out_load) begin
         rsp_glyph_ff <= res_glyph_ff;
         rsp_found_ff <= res_found_ff;
      end
   end

   assign stat.used_zero  = (used == '0);
   assign stat.issue_more = (issue_ff < used);
   assign stat.chk_valid  = chk_valid_ff;
   assign stat.end_ge     = (seg_rd_ff.last_code >= code_ff);
   assign stat.start_le   = (seg_rd_ff.first_code <= code_ff);
   assign stat.roff_zero  = (seg_rd_ff.range_offset == 16'd0);
   assign stat.scan_last  = ((UW'(chk_seg_ff) + UW'(1)) == used);
   assign stat.in_range   = !addr_ff[AW-1] && (addr_ff < AW'(GLYPH_WORDS));

   assign rsp_data.glyph_id      = rsp_glyph_ff;
   assign rsp_data.segment_found = rsp_found_ff;

endmodule

FILE: sv/cfgl_ctrl.sv
// Controller: sequences loads, the segment scan, the indirect read and the result beat.
`timescale 1ns / 1ps

module cfgl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic [1:0]         req_op,
   input  logic               rsp_ready,
   input  cfgl_pkg::stat_type stat,
   output cfgl_pkg::cmd_type  cmd,
   output logic               req_ready,
   output logic               rsp_valid
);
   import cfgl_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           out_valid_ff;
   logic           out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.res_sel = RES_MISS;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               case (req_op)
                  OP_LOAD_SEGMENT: cmd.seg_wr = 1'b1;
                  OP_LOAD_WORD:    cmd.word_wr = 1'b1;
                  OP_LOOKUP: begin
                     cmd.code_load  = 1'b1;
                     cmd.scan_clear = 1'b1;
                     if (stat.used_zero) begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_MISS;
                        state_in     = ST_DONE;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // memory data arrives in the cycle after its index is issued
            if (stat.chk_valid && stat.end_ge) begin
               if (!stat.start_le) begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = RES_MISS;
                  state_in     = ST_DONE;
               end else if (stat.roff_zero) begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = RES_DIRECT;
                  state_in     = ST_DONE;
               end else begin
                  state_in = ST_CALC;
               end
            end else if (stat.chk_valid && stat.scan_last) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_MISS;
               state_in     = ST_DONE;
            end else begin
               cmd.rd_en = stat.issue_more;
            end
         end
         ST_CALC: begin
            cmd.addr_load = 1'b1;
            state_in      = ST_GREAD;
         end
         ST_GREAD: begin
            if (stat.in_range) begin
               cmd.glyph_rd = 1'b1;
               state_in     = ST_GWAIT;
            end else begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_EMPTY;
               state_in     = ST_DONE;
            end
         end
         ST_GWAIT: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_WORD;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

FILE: sv/cmap_format4_glyph_lookup.sv
// Top level of the segment-map (cmap format 4) glyph lookup block.
`timescale 1ns / 1ps

// Translates 16-bit character codes to glyph indexes from a segment table and a
// glyph id word store that the request channel loads. Load beats (segment entry
// or glyph word) give no response. A lookup walks the segments through the
// single-read-port segment memory at one entry a cycle and holds the request
// side until its result is staged. It stops at the first segment whose end code
// covers the code and ends on the direct-delta path, on the indirect path, or
// with glyph 0 when the indirect address falls outside the store; with no
// covering segment, or no segment in use, it misses. The response register
// lets the next request be taken while the last result beat waits.
// The user must see that segment_count is written only while the block is idle;
// the block itself does not enforce this.
module cmap_format4_glyph_lookup #(
   parameter int MAX_SEGMENTS = 64,
   parameter int GLYPH_WORDS  = 1024
) (
   input  logic       clock,
   input  logic       reset,
   cfgl_req_if.sink   req_ch,
   cfgl_rsp_if.source rsp_ch,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data
);
   import cfgl_pkg::*;

   cmd_type  ctrl_cmd;
   stat_type dp_stat;
   logic     req_fire;
   logic     req_ready;
   logic     rsp_valid;

   assign req_fire     = req_ch.valid && req_ready;
   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

   cfgl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_op    (req_ch.data.operation),
      .rsp_ready (rsp_ch.ready),
      .stat      (dp_stat),
      .cmd       (ctrl_cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid)
   );

   cfgl_dp #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .GLYPH_WORDS  (GLYPH_WORDS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_ch.data),
      .cmd         (ctrl_cmd),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stat        (dp_stat),
      .rsp_data    (rsp_ch.data)
   );

   // the response register is only reloaded when empty or draining
   assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.out_load |-> (!rsp_valid || rsp_ch.ready))
      else $error("response register overwritten while holding a beat");

   // a lookup holds off further requests until its result is staged
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.data.operation == OP_LOOKUP) |=> !req_ready)
      else $error("request taken while a lookup is in flight");

   // load beats never produce a response beat
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.data.operation != OP_LOOKUP && !rsp_valid) |=> !rsp_valid)
      else $error("response beat after a load");

   // no covering segment means the missing glyph
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ch.data.segment_found) |-> (rsp_ch.data.glyph_id == 16'd0))
      else $error("nonzero glyph index without a segment");

endmodule
